// File: rtl/bfdh_pkg.sv
// package for the bloom filter double hash unit
// holds sizes, hash constants, operation codes and the queue entry type
// no dependencies
package bfdh_pkg;

  localparam int MaxBits    = 65536;
  localparam int MaxHashes  = 16;
  localparam int MinBits    = 64;
  localparam int HashW      = 64;
  localparam int BitIdxW    = $clog2(MaxBits);
  localparam int ModW       = BitIdxW + 1;
  localparam int HcntW      = $clog2(MaxHashes + 1);
  localparam int RowW       = 32;
  localparam int RowBitW    = $clog2(RowW);
  localparam int RowAw      = BitIdxW - RowBitW;
  localparam int RowsN      = MaxBits / RowW;
  localparam int ModCntW    = $clog2(HashW);
  localparam int CountW     = 32;
  localparam int CfgW       = 17;
  localparam int KeyW       = 8;

  localparam logic [HashW-1:0] FnvBasis   = 64'd14695981039346656037;
  localparam int               FnvShift   = 40;
  localparam logic [8:0]       FnvPrimeLo = 9'd435;
  localparam logic [HashW-1:0] DjbInit    = 64'd5381;

  localparam logic [CfgW-1:0]  BitsReset   = CfgW'(MaxBits);
  localparam logic [HcntW-1:0] HashesReset = HcntW'(4);

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic {
    CFG_NUM_BITS   = 1'b0,
    CFG_NUM_HASHES = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_CHK,
    ST_CLEAR,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    kind_e             kind;
    logic [HashW-1:0]  fnv;
    logic [HashW-1:0]  djb;
  } op_t;

endpackage

// File: rtl/bfdh_front.sv
// front end: accepts key bytes, runs fnv-1a and djb2, emits operations
// depends on bfdh_pkg
module bfdh_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              kind_i,
  input  logic                    byte_present_i,
  input  logic [bfdh_pkg::KeyW-1:0] key_byte_i,
  input  logic                    last_i,
  input  logic                    block_i,
  output logic                    push_o,
  output bfdh_pkg::op_t           push_op_o,
  input  logic                    full_i
);
  import bfdh_pkg::*;

  logic [HashW-1:0] fnv_q, fnv_d, djb_q, djb_d;
  logic [HashW-1:0] fnv_x, fnv_upd, djb_upd;
  logic             accept;

  assign in_ready_o = !block_i && !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // prime is 2^40 + 435
  assign fnv_x   = fnv_q ^ HashW'(key_byte_i);
  assign fnv_upd = (fnv_x << FnvShift) + (fnv_x * HashW'(FnvPrimeLo));
  assign djb_upd = (djb_q << 5) + djb_q + HashW'(key_byte_i);

  always_comb begin
    fnv_d          = fnv_q;
    djb_d          = djb_q;
    push_o         = 1'b0;
    push_op_o.kind = KIND_CLEAR;
    push_op_o.fnv  = byte_present_i ? fnv_upd : fnv_q;
    push_op_o.djb  = byte_present_i ? djb_upd : djb_q;
    if (accept) begin
      case (kind_i)
        KIND_CLEAR: begin
          push_o = 1'b1;
          fnv_d  = FnvBasis;
          djb_d  = DjbInit;
        end
        KIND_INSERT, KIND_QUERY: begin
          push_op_o.kind = kind_e'(kind_i);
          if (last_i) begin
            push_o = 1'b1;
            fnv_d  = FnvBasis;
            djb_d  = DjbInit;
          end else begin
            fnv_d = push_op_o.fnv;
            djb_d = push_op_o.djb;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fnv_q <= FnvBasis;
      djb_q <= DjbInit;
    end else begin
      fnv_q <= fnv_d;
      djb_q <= djb_d;
    end
  end

endmodule

// File: rtl/bfdh_fifo.sv
// two-entry queue of operations between front and back
// depends on bfdh_pkg
module bfdh_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bfdh_pkg::op_t push_op_i,
  output logic          full_o,
  output logic          valid_o,
  output bfdh_pkg::op_t op_o,
  input  logic          pop_i
);
  import bfdh_pkg::*;

  op_t        mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign op_o    = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// File: rtl/bfdh_back.sv
// back end: hash reduction, probe sequencing, bit store and result register
// depends on bfdh_pkg
module bfdh_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       op_valid_i,
  input  bfdh_pkg::op_t              op_i,
  output logic                       op_pop_o,
  input  logic [bfdh_pkg::ModW-1:0]  m_i,
  input  logic [bfdh_pkg::HcntW-1:0] k_i,
  output logic                       init_busy_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 done_kind_o,
  output logic                       may_contain_o,
  output logic [bfdh_pkg::CountW-1:0] key_total_o
);
  import bfdh_pkg::*;

  back_state_e state_q, state_d;

  logic [RowW-1:0]    mem [RowsN];
  logic [RowW-1:0]    rd_q;
  logic               mem_we;
  logic [RowAw-1:0]   mem_waddr;
  logic [RowW-1:0]    mem_wdata;

  kind_e              kind_q;
  logic [HashW-1:0]   fnv_sh_q, djb_sh_q;
  logic [BitIdxW-1:0] ra_q, rb_q, ra_d, rb_d, idx_q, idx_next;
  logic [ModW-1:0]    ta, tb, tsum;
  logic [ModCntW-1:0] mod_cnt_q;
  logic [HcntW-1:0]   probe_q;
  logic               all_set_q, bit_hit;
  logic [RowAw-1:0]   clr_row_q;
  logic               clr_last, mod_last, probe_last, load_out;

  logic               out_valid_q;
  kind_e              out_kind_q;
  logic               out_may_q;
  logic [CountW-1:0]  count_q;

  // restoring reduction, one hash bit per cycle
  assign ta   = {ra_q, fnv_sh_q[HashW-1]};
  assign tb   = {rb_q, djb_sh_q[HashW-1]};
  assign ra_d = (ta >= m_i) ? BitIdxW'(ta - m_i) : BitIdxW'(ta);
  assign rb_d = (tb >= m_i) ? BitIdxW'(tb - m_i) : BitIdxW'(tb);

  assign tsum     = {1'b0, idx_q} + {1'b0, rb_q};
  assign idx_next = (tsum >= m_i) ? BitIdxW'(tsum - m_i) : BitIdxW'(tsum);

  assign bit_hit    = rd_q[idx_q[RowBitW-1:0]];
  assign clr_last   = clr_row_q == {RowAw{1'b1}};
  assign mod_last   = mod_cnt_q == {ModCntW{1'b1}};
  assign probe_last = probe_q == (k_i - HcntW'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:  if (clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (op_valid_i) state_d = (op_i.kind == KIND_CLEAR) ? ST_CLEAR : ST_MOD;
      end
      ST_MOD:   if (mod_last) state_d = ST_RD;
      ST_RD:    state_d = ST_CHK;
      ST_CHK:   if (probe_last) state_d = ST_DONE; else state_d = ST_RD;
      ST_CLEAR: if (clr_last) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_pop_o    = 1'b0;
    init_busy_o = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[BitIdxW-1:RowBitW];
    mem_wdata   = rd_q | (RowW'(1) << idx_q[RowBitW-1:0]);
    load_out    = 1'b0;
    case (state_q)
      ST_INIT: begin
        init_busy_o = 1'b1;
        mem_we      = 1'b1;
        mem_waddr   = clr_row_q;
        mem_wdata   = '0;
      end
      ST_IDLE:  op_pop_o = op_valid_i;
      ST_CHK:   mem_we = kind_q == KIND_INSERT;
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_row_q;
        mem_wdata = '0;
      end
      ST_DONE:  load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[idx_q[BitIdxW-1:RowBitW]];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        kind_q    <= op_i.kind;
        fnv_sh_q  <= op_i.fnv;
        djb_sh_q  <= op_i.djb;
        ra_q      <= '0;
        rb_q      <= '0;
        mod_cnt_q <= '0;
      end
      ST_MOD: begin
        fnv_sh_q  <= fnv_sh_q << 1;
        djb_sh_q  <= djb_sh_q << 1;
        ra_q      <= ra_d;
        rb_q      <= rb_d;
        mod_cnt_q <= mod_cnt_q + ModCntW'(1);
        idx_q     <= ra_d;
        probe_q   <= '0;
        all_set_q <= 1'b1;
      end
      ST_CHK: begin
        all_set_q <= all_set_q & bit_hit;
        idx_q     <= idx_next;
        probe_q   <= probe_q + HcntW'(1);
      end
      default: ;
    endcase
    if (load_out) begin
      out_kind_q <= kind_q;
      out_may_q  <= (kind_q == KIND_QUERY) && all_set_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_row_q   <= '0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INIT || state_q == ST_CLEAR) begin
        clr_row_q <= clr_row_q + RowAw'(1);
      end else begin
        clr_row_q <= '0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        if (kind_q == KIND_CLEAR) begin
          count_q <= '0;
        end else if (kind_q == KIND_INSERT && count_q != {CountW{1'b1}}) begin
          count_q <= count_q + CountW'(1);
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign done_kind_o    = out_kind_q;
  assign may_contain_o  = out_may_q;
  assign key_total_o    = count_q;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD || state_q == ST_CHK) |-> ({1'b0, idx_q} < m_i))
    else $error("probe index not below bit count");
  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> ({1'b0, rb_q} < m_i))
    else $error("probe step not reduced");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == ST_DONE))
    else $error("result loaded outside done state");
  a_may_query_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q != KIND_QUERY) |-> !out_may_q)
    else $error("may_contain set on a non-query result");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop_o |=> (state_q == ST_MOD || state_q == ST_CLEAR))
    else $error("popped operation not started");
`endif

endmodule

// File: rtl/bloom_filter_double_hash_unit.sv
// top level of the bloom filter double hash unit
// depends on bfdh_pkg, bfdh_front, bfdh_fifo, bfdh_back
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in       | in_valid_i/in_ready_o  | kind_i byte_present_i key_byte_i last_i
//  out      | out_valid_o/out_ready_i| done_kind_o may_contain_o key_total_o
//  cfg      | cfg_we_i               | cfg_idx_i cfg_wdata_i
//
// a key byte is taken while the queue is not full; a key end starts
// a bit-serial reduction of both hashes by the bit count, then for each
// probe a registered bit store read, then a write or check; a clear
// sweeps the store one 32-bit row a cycle; the same pass runs after
// reset, and no input transaction is taken until it finishes
// a two-entry queue lets key bytes keep arriving while the back end works
module bloom_filter_double_hash_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic                          byte_present_i,
  input  logic [bfdh_pkg::KeyW-1:0]     key_byte_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    done_kind_o,
  output logic                          may_contain_o,
  output logic [bfdh_pkg::CountW-1:0]   key_total_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [bfdh_pkg::CfgW-1:0]     cfg_wdata_i
);
  import bfdh_pkg::*;

  logic [CfgW-1:0]  num_bits_q;
  logic [4:0]       hash_cnt_q;
  logic [ModW-1:0]  m_sat;
  logic [HcntW-1:0] k_sat;
  logic             push, full, op_valid, op_pop, init_busy;
  op_t              push_op, op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bits_q <= BitsReset;
      hash_cnt_q <= 5'(HashesReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NUM_BITS:   num_bits_q <= cfg_wdata_i;
        CFG_NUM_HASHES: hash_cnt_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_bits_q < CfgW'(MinBits))      m_sat = ModW'(MinBits);
    else if (num_bits_q > CfgW'(MaxBits)) m_sat = ModW'(MaxBits);
    else                                  m_sat = ModW'(num_bits_q);
    if (hash_cnt_q == 5'd0)               k_sat = HcntW'(1);
    else if (hash_cnt_q > 5'(MaxHashes))  k_sat = HcntW'(MaxHashes);
    else                                  k_sat = HcntW'(hash_cnt_q);
  end

  bfdh_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .byte_present_i (byte_present_i),
    .key_byte_i     (key_byte_i),
    .last_i         (last_i),
    .block_i        (init_busy),
    .push_o         (push),
    .push_op_o      (push_op),
    .full_i         (full)
  );

  bfdh_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .valid_o   (op_valid),
    .op_o      (op),
    .pop_i     (op_pop)
  );

  bfdh_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (op_valid),
    .op_i           (op),
    .op_pop_o       (op_pop),
    .m_i            (m_sat),
    .k_i            (k_sat),
    .init_busy_o    (init_busy),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .done_kind_o    (done_kind_o),
    .may_contain_o  (may_contain_o),
    .key_total_o    (key_total_o)
  );

endmodule
